### hw/rtl/ccbb_pkg.sv
// Shared types and constants for the checksummed command buffer bridge.
package ccbb_pkg;

  localparam logic [1:0] OP_RX      = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_SLOT    = 2'd2;

  localparam logic [7:0] CMD_VERSION = 8'h01;
  localparam logic [7:0] CMD_LIST    = 8'h08;
  localparam logic [7:0] CMD_SIZE    = 8'h10;
  localparam logic [7:0] CMD_CLEAR   = 8'h11;
  localparam logic [7:0] CMD_WRITE   = 8'h12;
  localparam logic [7:0] CMD_READ    = 8'h13;
  localparam logic [7:0] CMD_NOP     = 8'h14;

  localparam logic [2:0] REG_SIZE  = 3'd0;
  localparam logic [2:0] REG_VMAJ  = 3'd1;
  localparam logic [2:0] REG_VMIN  = 3'd2;
  localparam logic [2:0] REG_ACK   = 3'd3;
  localparam logic [2:0] REG_NACK  = 3'd4;

  localparam int MAX_RUN = 256;

  // byte source for the transmit path
  typedef enum logic [3:0] {
    SRC_ACK  = 4'd0,
    SRC_NACK = 4'd1,
    SRC_VMAJ = 4'd2,
    SRC_VMIN = 4'd3,
    SRC_LIST = 4'd4,
    SRC_SZHI = 4'd5,
    SRC_SZLO = 4'd6,
    SRC_MEM  = 4'd7,
    SRC_XOR  = 4'd8
  } src_t;

  typedef struct packed {
    logic       out_load;   // emit one byte
    src_t       src;
    logic [2:0] list_sel;   // 0 = count, 1..7 = codes
    logic       last;
    logic       cmd_load;
    logic       hi_load;
    logic       idx_lo_load;
    logic       len_load;
    logic       xor_clr;
    logic       wr_data;    // store byte, advance run
    logic       rd_issue;   // read memory at run index
    logic       rd_adv;     // fold read byte, advance run
    logic       clr_start;
    logic       clr_step;
  } ccbb_cmd_t;

  typedef struct packed {
    logic       out_busy;
    logic       out_taken;
    logic [7:0] cmd;
    logic       cmd_ok;     // rx byte is complement of command
    logic       known;
    logic       idx_ok;
    logic       len_ok;
    logic       sum_ok;
    logic       run_zero;   // write run exhausted
    logic       run_one;    // read run at its final byte
    logic       clr_done;
  } ccbb_sts_t;

  function automatic logic [7:0] list_byte(input logic [2:0] sel);
    logic [7:0] b;
    unique case (sel)
      3'd0: b = 8'd7;
      3'd1: b = CMD_VERSION;
      3'd2: b = CMD_LIST;
      3'd3: b = CMD_SIZE;
      3'd4: b = CMD_CLEAR;
      3'd5: b = CMD_WRITE;
      3'd6: b = CMD_READ;
      default: b = CMD_NOP;
    endcase
    return b;
  endfunction

endpackage

### hw/rtl/ccbb_datapath.sv
// Datapath: argument registers, byte memory, checksum and output register.
module ccbb_datapath #(
  parameter int BUF_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ccbb_pkg::ccbb_cmd_t cmd,
  output ccbb_pkg::ccbb_sts_t sts,
  input  logic [7:0]         rx_byte,
  input  logic [12:0]        buffer_size,
  input  logic [7:0]         ver_hi,
  input  logic [7:0]         ver_lo,
  input  logic [7:0]         ack_code,
  input  logic [7:0]         nack_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_tx_byte,
  output logic               out_last_of_run
);

  localparam int AW = $clog2(BUF_DEPTH);

  logic [7:0]  mem [BUF_DEPTH];
  logic [7:0]  cmd_r, hi_r, xor_r, rd_r;
  logic [15:0] idx_r;
  logic [8:0]  len_r;
  logic [16:0] clr_r;
  logic        ov_r, ol_r;
  logic [7:0]  ob_r, obyte;
  logic [16:0] usable;

  assign usable = ({4'd0, buffer_size} > 17'(BUF_DEPTH)) ? 17'(BUF_DEPTH)
                                                          : {4'd0, buffer_size};

  assign sts.out_busy  = ov_r;
  assign sts.out_taken = ov_r & out_ready;
  assign sts.cmd       = cmd_r;
  assign sts.cmd_ok    = (rx_byte ^ 8'hFF) == cmd_r;
  assign sts.known     = cmd_r == ccbb_pkg::CMD_VERSION || cmd_r == ccbb_pkg::CMD_LIST ||
                         cmd_r == ccbb_pkg::CMD_SIZE || cmd_r == ccbb_pkg::CMD_CLEAR ||
                         cmd_r == ccbb_pkg::CMD_WRITE || cmd_r == ccbb_pkg::CMD_READ ||
                         cmd_r == ccbb_pkg::CMD_NOP;
  assign sts.idx_ok    = ((hi_r ^ idx_r[7:0]) == rx_byte) && ({1'b0, idx_r} < usable);
  assign sts.len_ok    = ((8'(len_r - 9'd1) ^ 8'hFF) == rx_byte) &&
                         (({1'b0, idx_r} + 17'(len_r)) <= usable);
  assign sts.sum_ok    = rx_byte == xor_r;
  assign sts.run_zero  = len_r == 9'd0;
  assign sts.run_one   = len_r <= 9'd1;
  assign sts.clr_done  = clr_r >= usable;

  always_comb begin
    unique case (cmd.src)
      ccbb_pkg::SRC_ACK:  obyte = ack_code;
      ccbb_pkg::SRC_NACK: obyte = nack_code;
      ccbb_pkg::SRC_VMAJ: obyte = ver_hi;
      ccbb_pkg::SRC_VMIN: obyte = ver_lo;
      ccbb_pkg::SRC_LIST: obyte = ccbb_pkg::list_byte(cmd.list_sel);
      ccbb_pkg::SRC_SZHI: obyte = {3'd0, buffer_size[12:8]};
      ccbb_pkg::SRC_SZLO: obyte = buffer_size[7:0];
      ccbb_pkg::SRC_MEM:  obyte = ({1'b0, idx_r} < 17'(BUF_DEPTH)) ? rd_r : 8'd0;
      ccbb_pkg::SRC_XOR:  obyte = xor_r;
      default:            obyte = nack_code;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r  <= 1'b0;
      cmd_r <= '0;
      hi_r  <= '0;
      idx_r <= '0;
      len_r <= '0;
      xor_r <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.out_load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      if (cmd.cmd_load)    cmd_r <= rx_byte;
      if (cmd.hi_load)     hi_r  <= rx_byte;
      if (cmd.idx_lo_load) idx_r <= {hi_r, rx_byte};
      if (cmd.len_load)    len_r <= {1'b0, rx_byte} + 9'd1;
      if (cmd.xor_clr)     xor_r <= '0;
      if (cmd.wr_data) begin
        xor_r <= xor_r ^ rx_byte;
        idx_r <= idx_r + 16'd1;
        len_r <= len_r - 9'd1;
      end
      if (cmd.rd_adv) begin
        xor_r <= xor_r ^ obyte;
        idx_r <= idx_r + 16'd1;
        if (len_r != 9'd0) len_r <= len_r - 9'd1;
      end
      if (cmd.clr_start) clr_r <= '0;
      if (cmd.clr_step)  clr_r <= clr_r + 17'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      ob_r <= obyte;
      ol_r <= cmd.last;
    end
    if (cmd.rd_issue) begin
      rd_r <= mem[idx_r[AW-1:0]];
    end
    if (cmd.wr_data && ({1'b0, idx_r} < 17'(BUF_DEPTH))) begin
      mem[idx_r[AW-1:0]] <= rx_byte;
    end else if (cmd.clr_step) begin
      mem[clr_r[AW-1:0]] <= 8'hFF;
    end
  end

  assign out_valid       = ov_r;
  assign out_tx_byte     = ob_r;
  assign out_last_of_run = ol_r;

endmodule

### hw/rtl/ccbb_ctrl.sv
// Controller: command parser and reply sequencer.
module ccbb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  ccbb_pkg::ccbb_sts_t sts,
  output ccbb_pkg::ccbb_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_CHK   = 12'b000000000010,
    S_IHI   = 12'b000000000100,
    S_ILO   = 12'b000000001000,
    S_ICK   = 12'b000000010000,
    S_CNT   = 12'b000000100000,
    S_CCK   = 12'b000001000000,
    S_DATA  = 12'b000010000000,
    S_SEND  = 12'b000100000000,
    S_SUM   = 12'b001000000000,
    S_REPLY = 12'b010000000000,
    S_CLEAR = 12'b100000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] rstep_r, rstep_nxt;
  logic       rd_wait_r, rd_wait_nxt;
  logic       acc, room;

  assign room     = !sts.out_busy || sts.out_taken;
  assign in_ready = room && !rd_wait_r &&
                    (state_r != S_REPLY) && (state_r != S_CLEAR);
  assign acc      = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    rstep_nxt   = rstep_r;
    rd_wait_nxt = 1'b0;
    cmd         = '0;
    cmd.src     = ccbb_pkg::SRC_NACK;
    cmd.last    = 1'b1;
    unique case (state_r)
      S_REPLY: begin
        if (room) begin
          cmd.out_load = 1'b1;
          rstep_nxt    = rstep_r + 4'd1;
          priority if (sts.cmd == ccbb_pkg::CMD_VERSION) begin
            cmd.src = ccbb_pkg::SRC_VMIN;
            state_nxt = S_IDLE;
          end else if (sts.cmd == ccbb_pkg::CMD_SIZE) begin
            cmd.src = ccbb_pkg::SRC_SZLO;
            state_nxt = S_IDLE;
          end else begin
            cmd.src      = ccbb_pkg::SRC_LIST;
            cmd.list_sel = rstep_r[2:0];
            cmd.last     = rstep_r == 4'd7;
            if (rstep_r == 4'd7) state_nxt = S_IDLE;
          end
        end
      end
      S_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.clr_step = 1'b1;
        end
      end
      default: begin
        if (rd_wait_r) begin
          cmd.out_load = 1'b1;
          cmd.src      = ccbb_pkg::SRC_MEM;
          cmd.rd_adv   = 1'b1;
          if (sts.run_one) state_nxt = S_SUM;
        end else if (acc) begin
          priority if (in_op == ccbb_pkg::OP_RX) begin
            unique case (state_r)
              S_IDLE: begin
                cmd.cmd_load = 1'b1;
                state_nxt    = S_CHK;
              end
              S_CHK: begin
                cmd.out_load = 1'b1;
                state_nxt    = S_IDLE;
                if (sts.cmd_ok && sts.known) begin
                  cmd.src = ccbb_pkg::SRC_ACK;
                  priority if (sts.cmd == ccbb_pkg::CMD_VERSION) begin
                    cmd.last  = 1'b0;
                    cmd.src   = ccbb_pkg::SRC_ACK;
                    state_nxt = S_REPLY;
                  end else if (sts.cmd == ccbb_pkg::CMD_SIZE) begin
                    cmd.last  = 1'b0;
                    state_nxt = S_REPLY;
                  end else if (sts.cmd == ccbb_pkg::CMD_LIST) begin
                    cmd.last  = 1'b0;
                    state_nxt = S_REPLY;
                  end else if (sts.cmd == ccbb_pkg::CMD_CLEAR) begin
                    cmd.clr_start = 1'b1;
                    state_nxt     = S_CLEAR;
                  end else if (sts.cmd == ccbb_pkg::CMD_WRITE ||
                               sts.cmd == ccbb_pkg::CMD_READ) begin
                    state_nxt = S_IHI;
                  end else begin
                    state_nxt = S_IDLE;
                  end
                  rstep_nxt = 4'd0;
                end
              end
              S_IHI: begin
                cmd.hi_load = 1'b1;
                state_nxt   = S_ILO;
              end
              S_ILO: begin
                cmd.idx_lo_load = 1'b1;
                state_nxt       = S_ICK;
              end
              S_ICK: begin
                cmd.out_load = 1'b1;
                if (sts.idx_ok) begin
                  cmd.src   = ccbb_pkg::SRC_ACK;
                  state_nxt = S_CNT;
                end else begin
                  state_nxt = S_IDLE;
                end
              end
              S_CNT: begin
                cmd.len_load = 1'b1;
                state_nxt    = S_CCK;
              end
              S_CCK: begin
                cmd.out_load = 1'b1;
                if (sts.len_ok) begin
                  cmd.src     = ccbb_pkg::SRC_ACK;
                  cmd.xor_clr = 1'b1;
                  state_nxt   = (sts.cmd == ccbb_pkg::CMD_WRITE) ? S_DATA : S_SEND;
                end else begin
                  state_nxt = S_IDLE;
                end
              end
              S_DATA: begin
                if (!sts.run_zero) begin
                  cmd.wr_data = 1'b1;
                end else begin
                  cmd.out_load = 1'b1;
                  cmd.src = sts.sum_ok ? ccbb_pkg::SRC_ACK : ccbb_pkg::SRC_NACK;
                  state_nxt = S_IDLE;
                end
              end
              default: begin
              end
            endcase
          end else if (in_op == ccbb_pkg::OP_TIMEOUT) begin
            if (state_r == S_CHK) begin
              state_nxt = S_IDLE;
            end else if (state_r == S_IHI || state_r == S_ILO || state_r == S_ICK ||
                         state_r == S_CNT || state_r == S_CCK || state_r == S_DATA) begin
              cmd.out_load = 1'b1;
              state_nxt    = S_IDLE;
            end
          end else if (in_op == ccbb_pkg::OP_SLOT) begin
            if (state_r == S_SEND) begin
              cmd.rd_issue = 1'b1;
              rd_wait_nxt  = 1'b1;
            end else if (state_r == S_SUM) begin
              cmd.out_load = 1'b1;
              cmd.src      = ccbb_pkg::SRC_XOR;
              state_nxt    = S_IDLE;
            end
          end else begin
          end
        end
      end
    endcase
    if (state_r == S_REPLY && room && rstep_r == 4'd0 &&
        sts.cmd == ccbb_pkg::CMD_VERSION) begin
      cmd.src  = ccbb_pkg::SRC_VMAJ;
      cmd.last = 1'b0;
      state_nxt = S_REPLY;
    end
    if (state_r == S_REPLY && room && rstep_r == 4'd0 &&
        sts.cmd == ccbb_pkg::CMD_SIZE) begin
      cmd.src  = ccbb_pkg::SRC_SZHI;
      cmd.last = 1'b0;
      state_nxt = S_REPLY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rstep_r   <= '0;
      rd_wait_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rstep_r   <= rstep_nxt;
      rd_wait_r <= rd_wait_nxt;
    end
  end

endmodule

### hw/rtl/checksummed_command_buffer_bridge.sv
// Top level of the checksummed command buffer bridge.
// Timing: a reply byte appears in the cycle after the transfer that causes it;
// a read-out byte passes the registered memory read port, then the output register.
// Throughput: one item per cycle while the output has room; a read slot, a multi-byte
// reply or a clear of min(buffer_size, BUF_DEPTH) entries holds the input until done.
// Reset: synchronous active-low; registers return to their defaults, memory kept.
module checksummed_command_buffer_bridge #(
  parameter int BUF_DEPTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_tx_byte,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  ccbb_pkg::ccbb_cmd_t cmd;
  ccbb_pkg::ccbb_sts_t sts;
  logic [12:0] size_r;
  logic [7:0]  vmaj_r, vmin_r, ack_r, nack_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 13'd4096;
      vmaj_r <= 8'd1;
      vmin_r <= 8'd0;
      ack_r  <= 8'd121;
      nack_r <= 8'd31;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ccbb_pkg::REG_SIZE: size_r <= cfg_data;
        ccbb_pkg::REG_VMAJ: vmaj_r <= cfg_data[7:0];
        ccbb_pkg::REG_VMIN: vmin_r <= cfg_data[7:0];
        ccbb_pkg::REG_ACK:  ack_r  <= cfg_data[7:0];
        ccbb_pkg::REG_NACK: nack_r <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  ccbb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  ccbb_datapath #(.BUF_DEPTH(BUF_DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .rx_byte         (in_rx_byte),
    .buffer_size     (size_r),
    .ver_hi          (vmaj_r),
    .ver_lo          (vmin_r),
    .ack_code        (ack_r),
    .nack_code       (nack_r),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_tx_byte     (out_tx_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

### hw/rtl/ccbb_checker.sv
// Port-level checker for the bridge, bound to the top level.
module ccbb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_tx_byte,
  input logic       out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tx_byte))
    else $error("stalled output changed");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_reply_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run && !out_ready |-> !in_ready)
    else $error("input taken while reply run stalled");

endmodule

bind checksummed_command_buffer_bridge ccbb_checker u_ccbb_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_tx_byte     (out_tx_byte),
  .out_last_of_run (out_last_of_run)
);

### tb/sv/tb.sv
// Self-checking testbench for the checksummed command buffer bridge.
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH = 4096;
  localparam int F_NONE = 0;
  localparam int F_IDX  = 1;
  localparam int F_CNT  = 2;
  localparam int F_SUM  = 3;
  localparam int F_TMO  = 4;

  typedef enum logic [2:0] {
    PS_IDLE, PS_CHK, PS_INDEX, PS_COUNT, PS_DATA, PS_SEND, PS_SUM
  } parse_t;

  class ccbb_scoreboard;
    logic [12:0] size_q;
    logic [7:0]  vmaj, vmin, ack, nack;
    parse_t      ph;
    logic [7:0]  cmd, hi, run_xor;
    int          stage, run_len;
    logic [15:0] run_idx;
    logic [7:0]  mem [DEPTH];
    logic [7:0]  reply [$];
    logic [8:0]  tx_expected [$];
    int          errors, checked;

    function new();
      size_q = 13'd4096; vmaj = 8'd1; vmin = 8'd0; ack = 8'd121; nack = 8'd31;
      ph = PS_IDLE; cmd = '0; hi = '0; run_xor = '0; stage = 0; run_len = 0; run_idx = '0;
      errors = 0; checked = 0;
      foreach (mem[i]) mem[i] = 8'h00;
    endfunction

    function void set_reg(logic [2:0] idx, logic [12:0] val);
      case (idx)
        ccbb_pkg::REG_SIZE: size_q = val;
        ccbb_pkg::REG_VMAJ: vmaj = val[7:0];
        ccbb_pkg::REG_VMIN: vmin = val[7:0];
        ccbb_pkg::REG_ACK:  ack  = val[7:0];
        ccbb_pkg::REG_NACK: nack = val[7:0];
        default: ;
      endcase
    endfunction

    function int usable();
      return (size_q > DEPTH) ? DEPTH : int'(size_q);
    endfunction

    function void nak();
      ph = PS_IDLE;
      reply.push_back(nack);
    endfunction

    function void start_cmd();
      ph = PS_IDLE;
      case (cmd)
        ccbb_pkg::CMD_VERSION: begin
          reply.push_back(ack); reply.push_back(vmaj); reply.push_back(vmin);
        end
        ccbb_pkg::CMD_LIST: begin
          reply.push_back(ack); reply.push_back(8'd7);
          reply.push_back(ccbb_pkg::CMD_VERSION); reply.push_back(ccbb_pkg::CMD_LIST);
          reply.push_back(ccbb_pkg::CMD_SIZE); reply.push_back(ccbb_pkg::CMD_CLEAR);
          reply.push_back(ccbb_pkg::CMD_WRITE); reply.push_back(ccbb_pkg::CMD_READ);
          reply.push_back(ccbb_pkg::CMD_NOP);
        end
        ccbb_pkg::CMD_SIZE: begin
          reply.push_back(ack);
          reply.push_back({3'b000, size_q[12:8]}); reply.push_back(size_q[7:0]);
        end
        ccbb_pkg::CMD_CLEAR: begin
          reply.push_back(ack);
          for (int i = 0; i < usable(); i++) mem[i] = 8'hFF;
        end
        ccbb_pkg::CMD_WRITE, ccbb_pkg::CMD_READ: begin
          reply.push_back(ack);
          ph = PS_INDEX; stage = 0;
        end
        ccbb_pkg::CMD_NOP: reply.push_back(ack);
        default: nak();
      endcase
    endfunction

    function void take_byte(logic [7:0] b);
      case (ph)
        PS_IDLE: begin cmd = b; ph = PS_CHK; end
        PS_CHK: if ((b ^ 8'hFF) != cmd) nak(); else start_cmd();
        PS_INDEX:
          if (stage == 0) begin hi = b; stage = 1; end
          else if (stage == 1) begin run_idx = {hi, b}; stage = 2; end
          else if ((hi ^ run_idx[7:0]) != b || run_idx >= usable()) nak();
          else begin ph = PS_COUNT; stage = 0; reply.push_back(ack); end
        PS_COUNT:
          if (stage == 0) begin run_len = b + 1; stage = 1; end
          else if (((run_len - 1) ^ 8'hFF) != b || run_idx + run_len > usable()
                   || run_len > ccbb_pkg::MAX_RUN) nak();
          else begin
            run_xor = '0;
            ph = (cmd == ccbb_pkg::CMD_WRITE) ? PS_DATA : PS_SEND;
            reply.push_back(ack);
          end
        PS_DATA:
          if (run_len > 0) begin
            if (run_idx < DEPTH) mem[run_idx] = b;
            run_xor ^= b; run_idx++; run_len--;
          end else begin
            ph = PS_IDLE;
            reply.push_back((b == run_xor) ? ack : nack);
          end
        default: ;
      endcase
    endfunction

    function void note_input(logic [1:0] op, logic [7:0] b);
      logic [7:0] v;
      reply.delete();
      case (op)
        ccbb_pkg::OP_RX: if (ph != PS_SEND && ph != PS_SUM) take_byte(b);
        ccbb_pkg::OP_TIMEOUT:
          if (ph == PS_CHK) ph = PS_IDLE;
          else if (ph == PS_INDEX || ph == PS_COUNT || ph == PS_DATA) nak();
        ccbb_pkg::OP_SLOT:
          if (ph == PS_SEND) begin
            v = (run_idx < DEPTH) ? mem[run_idx] : 8'h00;
            run_xor ^= v; run_idx++;
            if (run_len > 0) run_len--;
            if (run_len == 0) ph = PS_SUM;
            reply.push_back(v);
          end else if (ph == PS_SUM) begin
            ph = PS_IDLE;
            reply.push_back(run_xor);
          end
        default: ;
      endcase
      foreach (reply[i]) tx_expected.push_back({i == reply.size() - 1, reply[i]});
    endfunction

    function void check(logic [7:0] tx, logic last);
      logic [8:0] e;
      checked++;
      if (tx_expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer tx_byte=%02h last=%0b", $time, tx, last);
        return;
      end
      e = tx_expected.pop_front();
      if (e[7:0] !== tx) begin
        errors++;
        $display("%0t: tx_byte expected %02h actual %02h", $time, e[7:0], tx);
      end
      if (e[8] !== last) begin
        errors++;
        $display("%0t: last_of_run expected %0b actual %0b", $time, e[8], last);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_op = 2'd0;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_tx_byte;
  logic        out_last_of_run;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [12:0] cfg_data = 13'd0;

  ccbb_scoreboard sb = new();
  int sender_idle = 21;
  int receiver_idle = 70;
  int hold_left = 0;
  bit hold_req = 0;
  int items = 0;

  checksummed_command_buffer_bridge DUT (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_idle);
    end
  end

  always @(posedge clk)
    if (rst_n && out_valid && out_ready) sb.check(out_tx_byte, out_last_of_run);

  task automatic send(logic [1:0] op, logic [7:0] b);
    while ($urandom_range(0, 99) < sender_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, b);
    items++;
  endtask

  task automatic rx(logic [7:0] b);
    send(ccbb_pkg::OP_RX, b);
  endtask

  function automatic logic [7:0] flip();
    return 8'd1 << $urandom_range(0, 7);
  endfunction

  task automatic cmd_pair(logic [7:0] c, bit good);
    rx(c);
    rx(good ? ~c : ~c ^ flip());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.tx_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic buffer_cmd(logic [7:0] c, logic [15:0] idx, logic [7:0] n, int fault);
    logic [7:0] sum;
    logic [7:0] d;
    sum = '0;
    cmd_pair(c, 1);
    if (sb.ph == PS_IDLE) return;
    rx(idx[15:8]);
    if (fault == F_TMO && c == ccbb_pkg::CMD_READ) begin
      send(ccbb_pkg::OP_TIMEOUT, 8'($urandom));
      return;
    end
    rx(idx[7:0]);
    rx(idx[15:8] ^ idx[7:0] ^ ((fault == F_IDX) ? flip() : 8'h00));
    if (sb.ph == PS_IDLE) return;
    rx(n);
    rx(~n ^ ((fault == F_CNT) ? flip() : 8'h00));
    if (sb.ph == PS_IDLE) return;
    if (c == ccbb_pkg::CMD_WRITE) begin
      for (int i = 0; i <= n; i++) begin
        if (fault == F_TMO && i == n / 2) begin
          send(ccbb_pkg::OP_TIMEOUT, 8'($urandom));
          return;
        end
        d = 8'($urandom);
        rx(d);
        sum ^= d;
      end
      rx(sum ^ ((fault == F_SUM) ? flip() : 8'h00));
    end else begin
      for (int i = 0; i <= n + 1; i++) begin
        if ($urandom_range(0, 9) == 0) rx(8'($urandom));
        if ($urandom_range(0, 19) == 0) send(ccbb_pkg::OP_TIMEOUT, 8'($urandom));
        send(ccbb_pkg::OP_SLOT, 8'($urandom));
      end
    end
  endtask

  task automatic random_run(int fault);
    int u, room;
    logic [15:0] idx;
    logic [7:0] n;
    u = sb.usable();
    idx = 16'($urandom_range(0, u - 1));
    room = u - int'(idx);
    n = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 63))
                                     : 8'($urandom_range(0, 7));
    if (int'(n) > room - 1) n = 8'(room - 1);
    buffer_cmd(($urandom_range(0, 1) != 0) ? ccbb_pkg::CMD_WRITE : ccbb_pkg::CMD_READ,
               idx, n, fault);
  endtask

  task automatic random_txn();
    int r, u, room;
    logic [15:0] idx;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    u = sb.usable();
    if (r < 60) begin
      random_run(F_NONE);
    end else if (r < 67) begin
      case ($urandom_range(0, 3))
        0: c = ccbb_pkg::CMD_VERSION;
        1: c = ccbb_pkg::CMD_LIST;
        2: c = ccbb_pkg::CMD_SIZE;
        default: c = ccbb_pkg::CMD_NOP;
      endcase
      cmd_pair(c, 1);
    end else if (r < 73) begin
      random_run(int'($urandom_range(F_IDX, F_TMO)));
    end else if (r < 77) begin
      idx = 16'($urandom_range(0, u - 1));
      room = u - int'(idx);
      if (room <= 255 && $urandom_range(0, 1) != 0)
        buffer_cmd(($urandom_range(0, 1) != 0) ? ccbb_pkg::CMD_WRITE : ccbb_pkg::CMD_READ,
                   idx, 8'($urandom_range(room, 255)), F_NONE);
      else
        buffer_cmd(ccbb_pkg::CMD_READ, 16'($urandom_range(u, 65535)), 8'($urandom),
                   F_NONE);
    end else if (r < 81) begin
      do c = 8'($urandom);
      while (c inside {ccbb_pkg::CMD_VERSION, ccbb_pkg::CMD_LIST, ccbb_pkg::CMD_SIZE,
                       ccbb_pkg::CMD_CLEAR, ccbb_pkg::CMD_WRITE, ccbb_pkg::CMD_READ,
                       ccbb_pkg::CMD_NOP});
      cmd_pair(c, 1);
    end else if (r < 85) begin
      cmd_pair(8'($urandom), 0);
    end else if (r < 89) begin
      rx(8'($urandom));
      send(ccbb_pkg::OP_TIMEOUT, 8'($urandom));
    end else if (r < 99) begin
      send(2'($urandom_range(1, 3)), 8'($urandom));
    end else begin
      cmd_pair(ccbb_pkg::CMD_CLEAR, 1);
    end
  endtask

  task automatic run_until(int target);
    while (items < target) random_txn();
  endtask

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill memory so that every later read hits written entries
    cmd_pair(ccbb_pkg::CMD_CLEAR, 1);
    cmd_pair(ccbb_pkg::CMD_VERSION, 1);
    cmd_pair(ccbb_pkg::CMD_LIST, 1);
    cmd_pair(ccbb_pkg::CMD_SIZE, 1);
    cmd_pair(ccbb_pkg::CMD_NOP, 1);
    cmd_pair(8'h15, 1);
    buffer_cmd(ccbb_pkg::CMD_WRITE, 16'(DEPTH - 2), 8'd1, F_NONE);
    buffer_cmd(ccbb_pkg::CMD_READ, 16'(DEPTH - 2), 8'd1, F_NONE);
    buffer_cmd(ccbb_pkg::CMD_READ, 16'hFFFF, 8'd0, F_NONE);
    send(2'd3, 8'hA5);

    hold_req = 1;
    repeat (4) cmd_pair(ccbb_pkg::CMD_LIST, 1);
    drain();

    run_until(130);
    drain();

    write_reg(ccbb_pkg::REG_SIZE, 13'd1);
    write_reg(ccbb_pkg::REG_VMAJ, 13'd255);
    write_reg(ccbb_pkg::REG_VMIN, 13'd255);
    write_reg(ccbb_pkg::REG_ACK, 13'd0);
    write_reg(ccbb_pkg::REG_NACK, 13'd255);
    sender_idle = 70;
    receiver_idle = 21;
    cmd_pair(ccbb_pkg::CMD_SIZE, 1);
    cmd_pair(ccbb_pkg::CMD_VERSION, 1);
    run_until(230);
    drain();

    write_reg(ccbb_pkg::REG_SIZE, 13'h1FFF);
    write_reg(ccbb_pkg::REG_VMIN, 13'd0);
    write_reg(ccbb_pkg::REG_ACK, 13'd255);
    write_reg(ccbb_pkg::REG_NACK, 13'd0);
    sender_idle = 0;
    receiver_idle = 0;
    cmd_pair(ccbb_pkg::CMD_SIZE, 1);
    buffer_cmd(ccbb_pkg::CMD_WRITE, 16'(DEPTH - 64), 8'd63, F_NONE);
    run_until(370);
    drain();
    repeat (20) @(posedge clk);

    $display("%0d input transfers, %0d result transfers checked, three register settings",
             items, sb.checked);
    if (sb.errors == 0 && sb.tx_expected.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.errors, sb.tx_expected.size());
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### sim.f
hw/rtl/ccbb_pkg.sv
hw/rtl/ccbb_datapath.sv
hw/rtl/ccbb_ctrl.sv
hw/rtl/checksummed_command_buffer_bridge.sv
hw/rtl/ccbb_checker.sv
tb/sv/tb.sv
